>>> rtl/core/edm_pkg.sv
`default_nettype none
package edm_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DIMS_DEF   = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int ROW_W   = 6;
  localparam int DIST_W  = 18;
  localparam int THR_W   = 18;
  localparam int DIMS_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;
  localparam logic [THR_W-1:0] THR_RESET = 18'd185363;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ACC, ST_SQRT, ST_EMIT, ST_DIAG, ST_STORE
  } state_t;
endpackage
`default_nettype wire

>>> rtl/core/edm_ram.sv
`default_nettype none
module edm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/edm_isqrt.sv
`default_nettype none
// Bit-pair restoring square root, one result bit per cycle.
module edm_isqrt #(
  parameter int IN_W = 64,
  parameter int OUT_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [IN_W-1:0]  radicand,
  output logic                  done,
  output logic      [OUT_W-1:0] root
);
  localparam int CNT_W = $clog2(OUT_W + 1);
  logic [IN_W-1:0]  x_r, x_nxt;
  logic [OUT_W+1:0] rem_r, rem_nxt;
  logic [OUT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [OUT_W+1:0] trial;
  logic [OUT_W+1:0] shifted;

  always_comb begin
    shifted = {rem_r[OUT_W-1:0], x_r[IN_W-1 -: 2]};
    trial   = {q_r, 2'b01};
    x_nxt = x_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done = 1'b0;
    if (start) begin
      x_nxt = radicand; rem_nxt = '0; q_nxt = '0;
      cnt_nxt = CNT_W'(OUT_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[IN_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        q_nxt = {q_r[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign root = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/core/euclidean_distance_matrix_core.sv
`default_nettype none
// Pairwise Euclidean distance rows. Each accepted item is a point; the core
// sends one result per earlier stored point (col_index ascending), then a zero
// diagonal result with last_of_row set. A point arriving when the store is full
// yields one overflow result and is dropped. One shared subtract/multiply/add
// unit walks the coordinates one per cycle from a point memory, and a
// bit-serial square root follows. in_tready is high only while idle.
module euclidean_distance_matrix_core #(
  parameter int MAX_POINTS = edm_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = edm_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS = edm_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // coord0..coord(MAX_DIMS-1), COORD_BITS each, zero fill to bytes
  input  wire logic [((MAX_DIMS*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tuser,   // start_set
  output logic      out_tvalid,
  input  wire logic out_tready,
  // row_index, col_index, distance, beyond_threshold, overflow
  output logic [31:0] out_tdata,
  output logic      out_tlast,  // last_of_row
  input  wire logic cfg_we,
  input  wire logic [edm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [edm_pkg::THR_W-1:0]     cfg_data
);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int AW  = PW + DW;
  localparam int CW  = PW + 1;
  localparam int IN_W = ((MAX_DIMS*COORD_BITS+7)/8)*8;
  localparam int DF_W = COORD_BITS + 1;
  localparam int SQ_W = 2*DF_W;
  localparam int SUM_W = 64;
  localparam int RT_W = 32;

  edm_pkg::state_t st_r, st_nxt;
  logic [edm_pkg::DIMS_W-1:0] dims_r;
  logic thr_en_r;
  logic [edm_pkg::THR_W-1:0] thr_r;
  logic [IN_W-1:0] pt_r, pt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] j_r, j_nxt;
  logic [DW:0] d_r, d_nxt;
  logic [DW:0] dims_eff;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic sq_v_r, sq_v_nxt;
  logic [edm_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [edm_pkg::DIST_W-1:0] rt_r, rt_nxt;
  logic beyond_r, beyond_nxt, ovf_r, ovf_nxt, last_r, last_nxt;
  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] row_r, row_nxt;
  logic ovalid_r, ovalid_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [COORD_BITS-1:0] ram_wdata, ram_rdata;
  logic sq_start, sq_done;
  logic [RT_W-1:0] sq_root;
  logic signed [DF_W-1:0] diff;
  logic [DF_W-1:0] mag;
  logic [COORD_BITS-1:0] cur_coord;
  logic [DW-1:0] d_idx;

  edm_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS*(1<<DW))) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata));

  edm_isqrt #(.IN_W(SUM_W), .OUT_W(RT_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_r),
    .done(sq_done), .root(sq_root));

  always_comb begin
    if (dims_r == '0) dims_eff = (DW+1)'(1);
    else if ({1'b0, dims_r} > 5'(MAX_DIMS)) dims_eff = (DW+1)'(MAX_DIMS);
    else dims_eff = (DW+1)'(dims_r);
  end

  assign in_tready = (st_r == edm_pkg::ST_IDLE) && !ovalid_r;
  assign d_idx = d_r[DW-1:0];

  always_comb begin
    // coordinate of the new point matching the registered RAM read data
    cur_coord = pt_r[COORD_BITS-1:0];
    for (int k = 0; k < MAX_DIMS; k++)
      if (d_r == (DW+1)'(k + 1)) cur_coord = pt_r[k*COORD_BITS +: COORD_BITS];
    diff = DF_W'($signed(cur_coord)) - DF_W'($signed(ram_rdata));
    mag = diff[DF_W-1] ? DF_W'(-diff) : DF_W'(diff);
  end

  always_comb begin
    st_nxt = st_r; pt_nxt = pt_r; cnt_nxt = cnt_r; j_nxt = j_r; d_nxt = d_r;
    sum_nxt = sum_r; sq_nxt = sq_r; sq_v_nxt = 1'b0;
    dist_nxt = dist_r; beyond_nxt = beyond_r; ovf_nxt = ovf_r; last_nxt = last_r;
    col_nxt = col_r; row_nxt = row_r; rt_nxt = rt_r; ovalid_nxt = ovalid_r;
    ram_we = 1'b0; ram_waddr = {cnt_r[PW-1:0], d_idx};
    ram_wdata = pt_r[COORD_BITS-1:0];
    for (int k = 0; k < MAX_DIMS; k++)
      if (d_idx == DW'(k)) ram_wdata = pt_r[k*COORD_BITS +: COORD_BITS];
    ram_raddr = {j_r, d_idx};
    sq_start = 1'b0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (st_r)
      edm_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          pt_nxt = in_tdata;
          if (in_tuser) cnt_nxt = '0;
          j_nxt = '0; d_nxt = '0; sum_nxt = '0;
          if ((in_tuser ? CW'(0) : cnt_r) >= CW'(MAX_POINTS)) begin
            dist_nxt = '0; beyond_nxt = 1'b0; ovf_nxt = 1'b1; last_nxt = 1'b1;
            col_nxt = '0; row_nxt = '0; ovalid_nxt = 1'b1;
          end else if ((in_tuser ? CW'(0) : cnt_r) == '0) begin
            st_nxt = edm_pkg::ST_DIAG;
          end else begin
            st_nxt = edm_pkg::ST_LOAD;
          end
        end
      end
      edm_pkg::ST_LOAD: begin
        // address of coord 0 presented; data arrives next cycle
        d_nxt = (DW+1)'(1);
        st_nxt = edm_pkg::ST_ACC;
      end
      edm_pkg::ST_ACC: begin
        // square of previous coordinate lands in sq_r, then is summed
        if (sq_v_r) sum_nxt = sum_r + SUM_W'(sq_r);
        if (d_r <= dims_eff && d_r != '0) begin
          sq_nxt = SQ_W'(mag) * SQ_W'(mag);
          sq_v_nxt = 1'b1;
          d_nxt = d_r + 1'b1;
          ram_raddr = {j_r, d_r[DW-1:0]};
        end else if (!sq_v_r) begin
          sq_start = 1'b1;
          st_nxt = edm_pkg::ST_SQRT;
        end else begin
          d_nxt = '0;
        end
      end
      edm_pkg::ST_SQRT: begin
        if (sq_done) begin
          rt_nxt = (sq_root > RT_W'(edm_pkg::DIST_MAX)) ? edm_pkg::DIST_MAX
                 : sq_root[edm_pkg::DIST_W-1:0];
          st_nxt = edm_pkg::ST_EMIT;
        end
      end
      edm_pkg::ST_EMIT: begin
        if (!ovalid_nxt) begin
          dist_nxt = rt_r;
          beyond_nxt = thr_en_r && (rt_r > thr_r);
          ovf_nxt = 1'b0; last_nxt = 1'b0; col_nxt = j_r; ovalid_nxt = 1'b1;
          row_nxt = cnt_r[PW-1:0];
          sum_nxt = '0; d_nxt = '0;
          if (CW'(j_r) + 1'b1 == cnt_r) begin
            st_nxt = edm_pkg::ST_DIAG;
          end else begin
            j_nxt = j_r + 1'b1;
            st_nxt = edm_pkg::ST_LOAD;
          end
        end
      end
      edm_pkg::ST_DIAG: begin
        if (!ovalid_nxt) begin
          dist_nxt = '0; beyond_nxt = 1'b0; ovf_nxt = 1'b0; last_nxt = 1'b1;
          col_nxt = cnt_r[PW-1:0]; row_nxt = cnt_r[PW-1:0]; ovalid_nxt = 1'b1;
          d_nxt = '0;
          st_nxt = edm_pkg::ST_STORE;
        end
      end
      edm_pkg::ST_STORE: begin
        ram_we = 1'b1;
        if (d_r == (DW+1)'(MAX_DIMS - 1)) begin
          cnt_nxt = cnt_r + 1'b1;
          st_nxt = edm_pkg::ST_IDLE;
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      default: st_nxt = edm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= edm_pkg::ST_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      sq_v_r <= 1'b0;
      dims_r <= edm_pkg::DIMS_RESET;
      thr_en_r <= 1'b0;
      thr_r <= edm_pkg::THR_RESET;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      sq_v_r <= sq_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          edm_pkg::REG_DIMS:   dims_r <= cfg_data[edm_pkg::DIMS_W-1:0];
          edm_pkg::REG_THR_EN: thr_en_r <= cfg_data[0];
          edm_pkg::REG_THR:    thr_r <= cfg_data;
          default: ;
        endcase
      end
    end
    pt_r <= pt_nxt; j_r <= j_nxt; d_r <= d_nxt; sum_r <= sum_nxt; sq_r <= sq_nxt;
    dist_r <= dist_nxt; beyond_r <= beyond_nxt; ovf_r <= ovf_nxt;
    last_r <= last_nxt; col_r <= col_nxt; row_r <= row_nxt; rt_r <= rt_nxt;
  end

  logic [edm_pkg::ROW_W-1:0] row_o, col_o;
  assign row_o = edm_pkg::ROW_W'(row_r);
  assign col_o = edm_pkg::ROW_W'(col_r);
  assign out_tvalid = ovalid_r;
  assign out_tlast = last_r;
  assign out_tdata = {ovf_r, beyond_r, dist_r, col_o, row_o};
endmodule
`default_nettype wire
